>>> rtl/mtlp_pkg.sv
// shared types and constants of the memory trace line parser
// no dependencies; every other file imports this package
package mtlp_pkg;

	localparam int unsigned NUM_TOKENS = 5;
	localparam int unsigned TOK_CNT_W  = $clog2(NUM_TOKENS + 1);
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned CORE_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ERR_W      = 3;

	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LC_F  = 8'h66;
	localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UC_F  = 8'h46;
	localparam logic [BYTE_W-1:0] CHAR_LC_X  = 8'h78;
	localparam logic [BYTE_W-1:0] CHAR_UC_X  = 8'h58;
	localparam logic [BYTE_W-1:0] CHAR_LC_O  = 8'h6f;
	localparam logic [BYTE_W-1:0] CHAR_UC_O  = 8'h4f;
	localparam logic [BYTE_W-1:0] CHAR_LC_R  = 8'h72;
	localparam logic [BYTE_W-1:0] CHAR_UC_R  = 8'h52;
	localparam logic [BYTE_W-1:0] CHAR_LC_W  = 8'h77;
	localparam logic [BYTE_W-1:0] CHAR_UC_W  = 8'h57;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE       = 3'd0,
		ERR_FEW_TOKENS = 3'd1,
		ERR_BAD_NUMBER = 3'd2,
		ERR_OP_LENGTH  = 3'd3,
		ERR_NO_ADDRESS = 3'd4
	} err_code_t;

	typedef logic [TOK_CNT_W-1:0] tok_count_t;

	// tokens of the current line as they stand once the open token is closed
	typedef struct packed {
		logic                                finish;
		tok_count_t                          count;
		logic [NUM_TOKENS-1:0]               bad;
		logic [NUM_TOKENS-1:0]               single;
		logic [BYTE_W-1:0]                   op_first;
		logic [BYTE_W-1:0]                   op_second;
		logic [NUM_TOKENS-1:0][VALUE_W-1:0]  value;
	} line_view_t;

endpackage

>>> rtl/mtlp_in_if.sv
// text byte channel of the trace line parser
// depends on mtlp_pkg
interface mtlp_in_if import mtlp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] text_byte;

	modport source(output valid, kind, text_byte, input ready);
	modport sink(input valid, kind, text_byte, output ready);
endinterface

>>> rtl/mtlp_out_if.sv
// access event channel of the trace line parser
// depends on mtlp_pkg
interface mtlp_out_if import mtlp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ERR_W-1:0]   error_code;
	logic [VALUE_W-1:0] stamp;
	logic [CORE_W-1:0]  core_number;
	logic               write_access;
	logic [VALUE_W-1:0] access_address;
	logic [VALUE_W-1:0] program_counter;
	logic               pc_present;
	logic               embeds_core;

	modport source(output valid, error_code, stamp, core_number, write_access,
		access_address, program_counter, pc_present, embeds_core, input ready);
	modport sink(input valid, error_code, stamp, core_number, write_access,
		access_address, program_counter, pc_present, embeds_core, output ready);
endinterface

>>> rtl/memory_trace_line_parser.sv
// Memory trace line parser. Takes one trace text byte (or an end-of-stream
// mark) per transfer and, at each line end that closes a non-blank line, gives
// one access event or an error code. One byte is taken every cycle unless the
// input side stalls: a byte goes into the input register, the tokenizer
// updates its number accumulator from it in the next cycle, and a line end
// loads the result register in the same cycle as the tokenizer takes it, so an
// event passes the input register and then the result register. The
// accumulator shift-add is the one loop that sets the byte rate.
// The input side stalls only when a line end meets a result that the sink has
// not yet taken; other bytes keep flowing behind a held result.
// depends on mtlp_pkg, mtlp_in_if, mtlp_out_if, mtlp_tokenizer, mtlp_line_eval
module memory_trace_line_parser import mtlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mtlp_in_if.sink           stream,
	mtlp_out_if.source        access,
	input  logic              default_core_we,
	input  logic [CORE_W-1:0] default_core_wdata
);

	logic              valid_s1;
	logic              kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [CORE_W-1:0] default_core_q;
	line_view_t        view;
	logic              produce;
	logic              adv;
	logic              in_xfer;

	assign produce = view.finish && view.count != '0;
	// hold the byte only if it would overwrite a result still waiting
	assign adv     = valid_s1 && !(produce && access.valid && !access.ready);
	assign stream.ready = !valid_s1 || adv;
	assign in_xfer = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			default_core_q <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (default_core_we) begin
				default_core_q <= default_core_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1 <= stream.kind;
			byte_s1 <= stream.text_byte;
		end
	end

	mtlp_tokenizer u_tokenizer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.kind      (kind_s1),
		.text_byte (byte_s1),
		.view      (view)
	);

	mtlp_line_eval u_line_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.view         (view),
		.load         (adv && produce),
		.default_core (default_core_q),
		.access       (access)
	);

endmodule

>>> rtl/mtlp_tokenizer.sv
// splits the byte stream into tokens and accumulates each token as a number
// depends on mtlp_pkg
module mtlp_tokenizer import mtlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              kind,
	input  logic [BYTE_W-1:0] text_byte,
	output line_view_t        view
);

	tok_count_t            count_q;
	logic                  inside_q;
	logic [1:0]            pos_q;
	logic                  hex_q;
	logic [VALUE_W-1:0]    acc_q;
	logic                  acc_bad_q;
	logic [BYTE_W-1:0]     first_q;
	logic [BYTE_W-1:0]     op_first_q;
	logic [BYTE_W-1:0]     op_second_q;
	logic [NUM_TOKENS-1:0] bad_q;
	logic [NUM_TOKENS-1:0] single_q;
	logic [VALUE_W-1:0]    value_q [NUM_TOKENS];

	logic                  is_eol;
	logic                  is_blank;
	logic                  commit_slot;
	logic [1:0]            pos;
	logic                  hex_e;
	logic [VALUE_W-1:0]    acc_e;
	logic                  bad_e;
	logic [BYTE_W-1:0]     first;
	logic                  hex_start;
	logic                  dig_ok;
	logic [3:0]            dig;
	logic [VALUE_W+3:0]    dec_sum;
	logic                  hex_n;
	logic [VALUE_W-1:0]    acc_n;
	logic                  bad_n;
	logic                  bad_base;
	logic [1:0]            pos_n;

	assign is_eol      = kind || text_byte == CHAR_CR || text_byte == CHAR_LF;
	assign is_blank    = !kind && (text_byte == CHAR_SPACE || text_byte == CHAR_TAB);
	assign commit_slot = inside_q && (count_q < NUM_TOKENS);

	// committed view of the line, open token folded into its slot
	always_comb begin
		view.finish    = is_eol;
		view.count     = count_q + tok_count_t'(commit_slot);
		view.op_first  = op_first_q;
		view.op_second = op_second_q;
		for (int i = 0; i < NUM_TOKENS; i++) begin
			if (commit_slot && count_q == tok_count_t'(i)) begin
				view.value[i]  = acc_q;
				view.bad[i]    = acc_bad_q;
				view.single[i] = (pos_q == 2'd1);
			end else begin
				view.value[i]  = value_q[i];
				view.bad[i]    = bad_q[i];
				view.single[i] = single_q[i];
			end
		end
	end

	// a new token starts from a clean accumulator
	assign pos   = inside_q ? pos_q : 2'd0;
	assign hex_e = (pos == 2'd0) ? 1'b0 : hex_q;
	assign acc_e = (pos == 2'd0) ? '0 : acc_q;
	assign bad_e = (pos == 2'd0) ? 1'b0 : acc_bad_q;
	assign first = (pos == 2'd0) ? text_byte : first_q;

	assign hex_start = pos == 2'd1 && !hex_e
		&& (text_byte == CHAR_LC_X || text_byte == CHAR_UC_X)
		&& (first == CHAR_0 || first == CHAR_UC_O || first == CHAR_LC_O);

	always_comb begin
		dig_ok = 1'b0;
		dig    = '0;
		if (text_byte >= CHAR_0 && text_byte <= CHAR_9) begin
			dig_ok = 1'b1;
			dig    = 4'(text_byte - CHAR_0);
		end else if (hex_e && text_byte >= CHAR_LC_A && text_byte <= CHAR_LC_F) begin
			dig_ok = 1'b1;
			dig    = 4'(text_byte - CHAR_LC_A + 8'd10);
		end else if (hex_e && text_byte >= CHAR_UC_A && text_byte <= CHAR_UC_F) begin
			dig_ok = 1'b1;
			dig    = 4'(text_byte - CHAR_UC_A + 8'd10);
		end
	end

	// acc * 10 + digit, anything above 64 bits is overflow
	assign dec_sum = ({4'b0, acc_e} << 3) + ({4'b0, acc_e} << 1)
		+ {{(VALUE_W){1'b0}}, dig};

	always_comb begin
		hex_n    = hex_e;
		acc_n    = acc_e;
		bad_n    = bad_e;
		bad_base = bad_e;
		if (hex_start) begin
			hex_n = 1'b1;
			acc_n = '0;
			bad_n = 1'b1;
		end else if (!dig_ok) begin
			bad_n = 1'b1;
		end else begin
			// first hex body digit clears the empty body mark
			if (hex_e && pos == 2'd2) begin
				bad_base = 1'b0;
			end
			bad_n = bad_base;
			if (!bad_base) begin
				if (hex_e) begin
					if (|acc_e[VALUE_W-1:VALUE_W-4]) begin
						bad_n = 1'b1;
					end else begin
						acc_n = {acc_e[VALUE_W-5:0], dig};
					end
				end else begin
					if (|dec_sum[VALUE_W+3:VALUE_W]) begin
						bad_n = 1'b1;
					end else begin
						acc_n = dec_sum[VALUE_W-1:0];
					end
				end
			end
		end
		pos_n = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			inside_q    <= 1'b0;
			pos_q       <= '0;
			hex_q       <= 1'b0;
			acc_q       <= '0;
			acc_bad_q   <= 1'b0;
			first_q     <= '0;
			op_first_q  <= '0;
			op_second_q <= '0;
			bad_q       <= '0;
			single_q    <= '0;
		end else if (step) begin
			if (is_eol) begin
				count_q  <= '0;
				inside_q <= 1'b0;
				pos_q    <= '0;
			end else if (is_blank) begin
				if (inside_q) begin
					if (commit_slot) begin
						bad_q[count_q[TOK_CNT_W-1:0]]    <= acc_bad_q;
						single_q[count_q[TOK_CNT_W-1:0]] <= (pos_q == 2'd1);
						count_q                          <= count_q + tok_count_t'(1);
					end
					inside_q <= 1'b0;
					pos_q    <= '0;
				end
			end else begin
				inside_q  <= 1'b1;
				pos_q     <= pos_n;
				hex_q     <= hex_n;
				acc_q     <= acc_n;
				acc_bad_q <= bad_n;
				if (pos == 2'd0) begin
					first_q <= text_byte;
					if (count_q == tok_count_t'(1)) begin
						op_first_q <= text_byte;
					end
					if (count_q == tok_count_t'(2)) begin
						op_second_q <= text_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !is_eol && is_blank && commit_slot) begin
			value_q[count_q[TOK_CNT_W-1:0]] <= acc_q;
		end
	end

endmodule

>>> rtl/mtlp_line_eval.sv
// checks a finished line, builds the access event and holds the result register
// depends on mtlp_pkg and mtlp_out_if
module mtlp_line_eval import mtlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  line_view_t        view,
	input  logic              load,
	input  logic [CORE_W-1:0] default_core,
	mtlp_out_if.source        access
);

	err_code_t          err;
	logic               set_core;
	logic               op_fmt;
	logic [VALUE_W-1:0] stamp_c;
	logic [CORE_W-1:0]  core_c;
	logic               write_c;
	logic [VALUE_W-1:0] addr_c;
	logic [VALUE_W-1:0] pc_c;
	logic               pc_present_c;

	logic               sticky_q;
	logic               valid_q;
	err_code_t          err_q;
	logic [VALUE_W-1:0] stamp_q;
	logic [CORE_W-1:0]  core_q;
	logic               write_q;
	logic [VALUE_W-1:0] addr_q;
	logic [VALUE_W-1:0] pc_q;
	logic               pc_present_q;
	logic               embeds_q;

	assign op_fmt = view.single[1] && (view.op_first == CHAR_UC_R
		|| view.op_first == CHAR_LC_R || view.op_first == CHAR_UC_W
		|| view.op_first == CHAR_LC_W);

	always_comb begin
		err          = ERR_NONE;
		set_core     = 1'b0;
		stamp_c      = '0;
		core_c       = '0;
		write_c      = 1'b0;
		addr_c       = '0;
		pc_c         = '0;
		pc_present_c = 1'b0;
		if (view.count < tok_count_t'(3)) begin
			err = ERR_FEW_TOKENS;
		end else if (view.bad[0]) begin
			err = ERR_BAD_NUMBER;
		end else if (op_fmt) begin
			if (view.bad[2] || (view.count >= tok_count_t'(4) && view.bad[3])) begin
				err = ERR_BAD_NUMBER;
			end else begin
				stamp_c      = view.value[0];
				core_c       = default_core;
				write_c      = view.op_first == CHAR_UC_W || view.op_first == CHAR_LC_W;
				addr_c       = view.value[2];
				pc_present_c = view.count >= tok_count_t'(4);
				pc_c         = pc_present_c ? view.value[3] : '0;
			end
		end else begin
			// core format is latched before the core field itself is checked
			set_core = 1'b1;
			if (view.bad[1]) begin
				err = ERR_BAD_NUMBER;
			end else if (!view.single[2]) begin
				err = ERR_OP_LENGTH;
			end else if (view.count < tok_count_t'(4)) begin
				err = ERR_NO_ADDRESS;
			end else if (view.bad[3]
				|| (view.count >= tok_count_t'(5) && view.bad[4])) begin
				err = ERR_BAD_NUMBER;
			end else begin
				stamp_c      = view.value[0];
				core_c       = view.value[1][CORE_W-1:0];
				write_c      = view.op_second == CHAR_UC_W || view.op_second == CHAR_LC_W;
				addr_c       = view.value[3];
				pc_present_c = view.count >= tok_count_t'(5);
				pc_c         = pc_present_c ? view.value[4] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load) begin
				sticky_q <= sticky_q | set_core;
				valid_q  <= 1'b1;
			end else if (access.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_q        <= err;
			stamp_q      <= stamp_c;
			core_q       <= core_c;
			write_q      <= write_c;
			addr_q       <= addr_c;
			pc_q         <= pc_c;
			pc_present_q <= pc_present_c;
			embeds_q     <= sticky_q | set_core;
		end
	end

	assign access.valid           = valid_q;
	assign access.error_code      = err_q;
	assign access.stamp           = stamp_q;
	assign access.core_number     = core_q;
	assign access.write_access    = write_q;
	assign access.access_address  = addr_q;
	assign access.program_counter = pc_q;
	assign access.pc_present      = pc_present_q;
	assign access.embeds_core     = embeds_q;

endmodule

>>> rtl/mtlp_checker.sv
// port-level checks of the trace line parser, attached by bind
// depends on mtlp_pkg and memory_trace_line_parser
module mtlp_checker import mtlp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ERR_W-1:0]   error_code,
	input logic [VALUE_W-1:0] stamp,
	input logic [CORE_W-1:0]  core_number,
	input logic               write_access,
	input logic [VALUE_W-1:0] access_address,
	input logic [VALUE_W-1:0] program_counter,
	input logic               pc_present,
	input logic               embeds_core
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(stamp)
			&& $stable(access_address) && $stable(program_counter))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> stamp == '0 && core_number == '0
			&& !write_access && access_address == '0 && program_counter == '0
			&& !pc_present)
		else $error("error result carries event fields");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code == ERR_NONE || error_code == ERR_FEW_TOKENS
			|| error_code == ERR_BAD_NUMBER || error_code == ERR_OP_LENGTH
			|| error_code == ERR_NO_ADDRESS)
		else $error("error code out of range");

	// core format flag never drops once shown
	a_core_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && embeds_core |=> !out_valid || embeds_core)
		else $error("core format flag cleared");

	a_pc_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pc_present |-> program_counter == '0)
		else $error("pc value without pc token");

endmodule

bind memory_trace_line_parser mtlp_checker u_mtlp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (access.valid),
	.out_ready       (access.ready),
	.error_code      (access.error_code),
	.stamp           (access.stamp),
	.core_number     (access.core_number),
	.write_access    (access.write_access),
	.access_address  (access.access_address),
	.program_counter (access.program_counter),
	.pc_present      (access.pc_present),
	.embeds_core     (access.embeds_core)
);

>>> bench/tb_memory_trace_line_parser.sv
// testbench of memory_trace_line_parser: drives trace text byte by byte, predicts the
// access events in a scoreboard class and compares every event field by field
// depends on mtlp_pkg, mtlp_in_if, mtlp_out_if and the parser rtl
`timescale 1ns / 100ps

module tb_memory_trace_line_parser;
	import mtlp_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned PHASE_BYTES  = 215;
	localparam int unsigned PHASE_EVENTS = 5;
	localparam int unsigned SETTLE       = 8;

	typedef struct packed {
		err_code_t          err;
		logic [VALUE_W-1:0] stamp;
		logic [CORE_W-1:0]  core;
		logic               wr;
		logic [VALUE_W-1:0] addr;
		logic [VALUE_W-1:0] pc;
		logic               pc_ok;
		logic               emb;
	} access_event_t;

	class line_event_board;
		access_event_t      expected_events[$];
		int unsigned        failures;
		int unsigned        predicted;
		logic [CORE_W-1:0]  core_default;
		logic [VALUE_W-1:0] tok_val [NUM_TOKENS];
		logic               tok_bad [NUM_TOKENS];
		logic               tok_single [NUM_TOKENS];
		logic [BYTE_W-1:0]  tok_first [NUM_TOKENS];
		int unsigned        tok_cnt;
		int unsigned        pos;
		bit                 in_tok;
		bit                 hexm;
		bit                 acc_bad;
		bit                 core_seen;
		logic [VALUE_W-1:0] acc;

		function new();
			failures = 0;
			predicted = 0;
			core_default = '0;
			for (int i = 0; i < NUM_TOKENS; i++) begin
				tok_val[i] = '0;
				tok_bad[i] = 1'b0;
				tok_single[i] = 1'b0;
				tok_first[i] = '0;
			end
			tok_cnt = 0;
			pos = 0;
			in_tok = 0;
			hexm = 0;
			acc_bad = 0;
			core_seen = 0;
			acc = '0;
		endfunction

		function void set_core(logic [CORE_W-1:0] v);
			core_default = v;
		endfunction

		// 5'h1f: not a digit of the current base
		function logic [4:0] digit_of(logic [BYTE_W-1:0] c, bit hex);
			if (c >= CHAR_0 && c <= CHAR_9)
				return 5'(c - CHAR_0);
			if (hex && c >= CHAR_LC_A && c <= CHAR_LC_F)
				return 5'(c - CHAR_LC_A + 10);
			if (hex && c >= CHAR_UC_A && c <= CHAR_UC_F)
				return 5'(c - CHAR_UC_A + 10);
			return 5'h1f;
		endfunction

		function bit write_op_char(logic [BYTE_W-1:0] c);
			return c == CHAR_UC_W || c == CHAR_LC_W;
		endfunction

		function bit is_op(logic [BYTE_W-1:0] c);
			return c == CHAR_UC_R || c == CHAR_LC_R || write_op_char(c);
		endfunction

		function void accumulate(logic [BYTE_W-1:0] c);
			logic [4:0]         d;
			logic [VALUE_W-1:0] dv;
			logic [BYTE_W-1:0]  first;
			int unsigned        p;
			p = pos;
			if (p == 0) begin
				if (tok_cnt < NUM_TOKENS)
					tok_first[tok_cnt] = c;
				hexm = 0;
				acc = '0;
				acc_bad = 0;
			end
			first = (tok_cnt < NUM_TOKENS) ? tok_first[tok_cnt] : '0;
			if (p == 1 && !hexm && (c == CHAR_LC_X || c == CHAR_UC_X) &&
				(first == CHAR_0 || first == CHAR_UC_O || first == CHAR_LC_O)) begin
				// prefix seen, body still empty
				hexm = 1;
				acc = '0;
				acc_bad = 1;
			end else begin
				d = digit_of(c, hexm);
				dv = 64'(d);
				if (d == 5'h1f) begin
					acc_bad = 1;
				end else begin
					if (hexm && p == 2)
						acc_bad = 0;
					if (!acc_bad) begin
						if (hexm) begin
							if (acc[63:60] != 4'h0)
								acc_bad = 1;
							else
								acc = {acc[59:0], dv[3:0]};
						end else begin
							if (acc > (64'hFFFF_FFFF_FFFF_FFFF - dv) / 64'd10)
								acc_bad = 1;
							else
								acc = acc * 64'd10 + dv;
						end
					end
				end
			end
			pos = (p < 3) ? p + 1 : 3;
		endfunction

		function void close_token();
			if (!in_tok)
				return;
			if (tok_cnt < NUM_TOKENS) begin
				tok_val[tok_cnt] = acc;
				tok_bad[tok_cnt] = acc_bad;
				tok_single[tok_cnt] = (pos == 1);
				tok_cnt++;
			end
			in_tok = 0;
			pos = 0;
		endfunction

		function access_event_t error_event(err_code_t e);
			access_event_t ev;
			ev = '0;
			ev.err = e;
			ev.emb = core_seen;
			return ev;
		endfunction

		function void close_line();
			access_event_t ev;
			int unsigned   n;
			close_token();
			n = tok_cnt;
			tok_cnt = 0;
			if (n == 0)
				return;
			ev = '0;
			if (n < 3) begin
				ev = error_event(ERR_FEW_TOKENS);
			end else if (tok_bad[0]) begin
				ev = error_event(ERR_BAD_NUMBER);
			end else if (tok_single[1] && is_op(tok_first[1])) begin
				if (tok_bad[2] || (n >= 4 && tok_bad[3])) begin
					ev = error_event(ERR_BAD_NUMBER);
				end else begin
					ev.err = ERR_NONE;
					ev.stamp = tok_val[0];
					ev.core = core_default;
					ev.wr = write_op_char(tok_first[1]);
					ev.addr = tok_val[2];
					if (n >= 4) begin
						ev.pc = tok_val[3];
						ev.pc_ok = 1'b1;
					end
					ev.emb = core_seen;
				end
			end else begin
				// core format: the sticky flag goes up before the core field is checked
				core_seen = 1;
				if (tok_bad[1])
					ev = error_event(ERR_BAD_NUMBER);
				else if (!tok_single[2])
					ev = error_event(ERR_OP_LENGTH);
				else if (n < 4)
					ev = error_event(ERR_NO_ADDRESS);
				else if (tok_bad[3] || (n >= 5 && tok_bad[4]))
					ev = error_event(ERR_BAD_NUMBER);
				else begin
					ev.err = ERR_NONE;
					ev.stamp = tok_val[0];
					ev.core = tok_val[1][CORE_W-1:0];
					ev.wr = write_op_char(tok_first[2]);
					ev.addr = tok_val[3];
					if (n >= 5) begin
						ev.pc = tok_val[4];
						ev.pc_ok = 1'b1;
					end
					ev.emb = 1'b1;
				end
			end
			expected_events.push_back(ev);
			predicted++;
		endfunction

		// one accepted input transfer
		function void parse_byte(logic k, logic [BYTE_W-1:0] c);
			if (k || c == CHAR_CR || c == CHAR_LF) begin
				close_line();
			end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
				close_token();
			end else begin
				if (!in_tok) begin
					in_tok = 1;
					pos = 0;
				end
				accumulate(c);
			end
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction

		function string event_text(access_event_t ev);
			return $sformatf("err=%0d stamp=%h core=%h wr=%b addr=%h pc=%h pc_ok=%b emb=%b",
				ev.err, ev.stamp, ev.core, ev.wr, ev.addr, ev.pc, ev.pc_ok, ev.emb);
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void check_event(access_event_t got);
			access_event_t want;
			if (expected_events.size() == 0) begin
				report({"unexpected event: ", event_text(got)});
				return;
			end
			want = expected_events.pop_front();
			if (got.err !== want.err || got.stamp !== want.stamp || got.core !== want.core ||
				got.wr !== want.wr || got.addr !== want.addr || got.pc !== want.pc ||
				got.pc_ok !== want.pc_ok || got.emb !== want.emb)
				report({"event mismatch\n  expected ", event_text(want),
					"\n  actual   ", event_text(got)});
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              default_core_we;
	logic [CORE_W-1:0] default_core_wdata;

	mtlp_in_if  stream_if ();
	mtlp_out_if access_if ();

	line_event_board board = new();

	int unsigned sent_bytes = 0;
	bit          tx_idle_on = 0;
	bit          rx_idle_on = 0;
	bit          hold_request = 0;

	memory_trace_line_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.access(access_if),
		.default_core_we(default_core_we),
		.default_core_wdata(default_core_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("memory_trace_line_parser test failed");
		$finish;
	end

	// mostly short, now and then long
	function automatic int unsigned idle_length();
		if ($urandom_range(0, 99) < 75)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input logic k, input logic [BYTE_W-1:0] c);
		int unsigned gap;
		gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.kind <= k;
		stream_if.text_byte <= c;
		do
			@(posedge clk);
		while (!stream_if.ready);
		board.parse_byte(k, c);
		sent_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic end_stream();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic write_core(input logic [CORE_W-1:0] v);
		default_core_we <= 1'b1;
		default_core_wdata <= v;
		@(posedge clk);
		default_core_we <= 1'b0;
		board.set_core(v);
	endtask

	task automatic drain_events();
		stream_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic string hex_prefix();
		case ($urandom_range(0, 5))
			0: return "0x";
			1: return "0X";
			2: return "Ox";
			3: return "OX";
			4: return "ox";
			default: return "oX";
		endcase
	endfunction

	function automatic string number_text();
		logic [VALUE_W-1:0] v;
		string              body;
		int unsigned        pick;
		byte                ch;
		pick = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (pick == 0)
			v = '1;
		else if (pick == 1)
			v = '0;
		else if (pick < 4)
			v = v >> $urandom_range(0, 8);
		else
			v = v >> $urandom_range(40, 63);
		if ($urandom_range(0, 1)) begin
			body = $sformatf("%0d", v);
			if ($urandom_range(0, 7) == 0)
				body = {"00", body};
			return body;
		end
		body = $sformatf("%0h", v);
		if ($urandom_range(0, 7) == 0)
			body = {"000", body};
		for (int i = 0; i < body.len(); i++) begin
			ch = body[i];
			if (ch >= "a" && $urandom_range(0, 1))
				body[i] = ch - 8'd32;
		end
		return {hex_prefix(), body};
	endfunction

	function automatic string bad_number_text();
		string s;
		case ($urandom_range(0, 5))
			0: begin
				// 21 decimal digits, above the 64-bit range
				s = "1";
				repeat (20) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
			end
			1: s = {"0x", $sformatf("%0h%016h", $urandom_range(1, 15), {$urandom, $urandom})};
			2: s = hex_prefix();
			3: begin
				if ($urandom_range(0, 1))
					s = {"-", number_text()};
				else
					s = {"+", number_text()};
			end
			4: s = {number_text(), $sformatf("%c", $urandom_range(8'h67, 8'h7a))};
			default: s = {hex_prefix(), "1g"};
		endcase
		return s;
	endfunction

	function automatic string token_text();
		if ($urandom_range(0, 99) < 8)
			return bad_number_text();
		return number_text();
	endfunction

	function automatic string op_text(bit core_fmt);
		if (!core_fmt || $urandom_range(0, 99) < 85) begin
			case ($urandom_range(0, 3))
				0: return "R";
				1: return "r";
				2: return "W";
				default: return "w";
			endcase
		end
		return $sformatf("%c", $urandom_range(8'h21, 8'hff));
	endfunction

	function automatic string blank_text();
		string s;
		s = ($urandom_range(0, 3) == 0) ? "\t" : " ";
		if ($urandom_range(0, 5) == 0)
			s = {s, " "};
		return s;
	endfunction

	function automatic string line_text(bit core_fmt);
		string       tok[$];
		string       s;
		int unsigned r;
		int unsigned op_at;
		tok.push_back(token_text());
		if (core_fmt)
			tok.push_back(token_text());
		op_at = tok.size();
		tok.push_back(op_text(core_fmt));
		tok.push_back(token_text());
		if ($urandom_range(0, 1))
			tok.push_back(token_text());
		r = $urandom_range(0, 99);
		if (r < 3)
			tok[op_at] = {tok[op_at], "w"};
		else if (r < 8)
			repeat ($urandom_range(1, 3)) tok.delete($urandom_range(0, tok.size() - 1));
		else if (r < 12)
			repeat ($urandom_range(1, 3)) tok.push_back(token_text());
		s = ($urandom_range(0, 7) == 0) ? blank_text() : "";
		foreach (tok[i]) begin
			if (i > 0)
				s = {s, blank_text()};
			s = {s, tok[i]};
		end
		if ($urandom_range(0, 7) == 0)
			s = {s, blank_text()};
		return s;
	endfunction

	task automatic send_random_line();
		int unsigned r;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom_range(0, 255)));
			send_text("\n");
			return;
		end
		send_text(line_text($urandom_range(0, 99) < 45));
		r = $urandom_range(0, 99);
		if (r < 60)
			send_text("\n");
		else if (r < 75)
			send_text("\015");
		else if (r < 90)
			send_text("\015\n");
		else
			end_stream();
	endtask

	// result side: check each transfer, then choose ready for the next cycle
	initial begin : event_sink
		access_event_t got;
		int unsigned   hold_left;
		hold_left = 0;
		access_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && access_if.valid && access_if.ready) begin
				got.err = err_code_t'(access_if.error_code);
				got.stamp = access_if.stamp;
				got.core = access_if.core_number;
				got.wr = access_if.write_access;
				got.addr = access_if.access_address;
				got.pc = access_if.program_counter;
				got.pc_ok = access_if.pc_present;
				got.emb = access_if.embeds_core;
				board.check_event(got);
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				access_if.ready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
				hold_left = idle_length() - 1;
				access_if.ready <= 1'b0;
			end else begin
				access_if.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [CORE_W-1:0] phase_core [4];
		int unsigned       mark_bytes;
		int unsigned       mark_events;
		arst_n = 1'b0;
		default_core_we = 1'b0;
		default_core_wdata = '0;
		stream_if.valid = 1'b0;
		stream_if.kind = 1'b0;
		stream_if.text_byte = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_core('1);
		tx_idle_on = 1;
		rx_idle_on = 1;
		send_text("0 R 0\n");
		send_text("18446744073709551615 W 0xFFFFFFFFFFFFFFFF 18446744073709551615\n");
		send_text("5 w 0X1f Ox10\n");
		send_text("7 r oXaB oX\n");
		send_text("18446744073709551616 R 1\n");
		send_text("1 R 0x10000000000000000\n");
		send_text("1 2\n");
		send_text("12 3 R 0x40\n");
		send_text("12\t4294967296 Q OXdead 99\015\n");
		send_text("1 2 RW 3\n");
		send_text("1 2 W\n");
		send_text("1 -2 W 3\n");
		send_text("1 x 2\n");
		send_text("  1 2 W 3 4 5 6\t7  \n");
		send_text("+1 R 2\n");
		send_text("3 r 000000000000000000000042 0x00000000000000000001\015");
		send_text(" \t \n");
		send_text("\tOx 3 W 4");
		end_stream();
		send_text("9 W 8");
		end_stream();
		end_stream();
		send_text("1 R 5\001\n");
		send_text("4 R 2 0x7g\n");
		send_text("00x5 R 2\n");
		drain_events();

		phase_core = '{32'h0, 32'($urandom), 32'h8000_0000, 32'h1};
		for (int p = 0; p < 4; p++) begin
			write_core(phase_core[p]);
			tx_idle_on = (p != 1);
			rx_idle_on = (p != 3);
			// long hold-off on the result side while bytes keep coming
			if (p == 2)
				hold_request = 1;
			mark_bytes = sent_bytes;
			mark_events = board.predicted;
			while (sent_bytes - mark_bytes < PHASE_BYTES ||
				board.predicted - mark_events < PHASE_EVENTS)
				send_random_line();
			drain_events();
		end

		if (board.failures == 0)
			$display("memory_trace_line_parser test passed");
		else
			$display("memory_trace_line_parser test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/mtlp_pkg.sv
rtl/mtlp_in_if.sv
rtl/mtlp_out_if.sv
rtl/mtlp_tokenizer.sv
rtl/mtlp_line_eval.sv
rtl/memory_trace_line_parser.sv
rtl/mtlp_checker.sv
bench/tb_memory_trace_line_parser.sv
